// ===== rtl/t2r_pkg.sv =====
// Shared types and constants for the 2bpp tile to raster converter.
// Depends on nothing; used by t2r_ctrl, t2r_dpath and the top level.
package t2r_pkg;

    // Input command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_TILES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_TILES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_3    = 3'd5;

    // Reset values of the configuration registers
    localparam logic [3:0]  SIDE_RESET     = 4'd7;
    localparam logic [23:0] PALETTE0_RESET = 24'hffffff;
    localparam logic [23:0] PALETTE1_RESET = 24'haaaaaa;
    localparam logic [23:0] PALETTE2_RESET = 24'h555555;
    localparam logic [23:0] PALETTE3_RESET = 24'h000000;

    localparam logic [1:0] GRAY_MAX = 2'd3;
    localparam int PIXELS_PER_SPAN = 8;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_start;   // latch planes and start tile division
        logic div_step;     // one restoring division step
        logic write_row;    // write interleaved row into the store
        logic read_start;   // read next span from the store
        logic emit;         // load one pixel into the output register
        logic span_done;    // advance the read counter or clear both counters
    } t2r_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic load_ok;      // image not yet fully loaded
        logic image_full;   // all rows loaded, reads allowed
        logic div_last;     // final division step this cycle
        logic out_free;     // output register can take a word
        logic pix_last;     // eighth pixel of the span is next
    } t2r_status_t;

    // Interleave two bitplanes into eight 2-bit indices, leftmost in bits 15..14
    function automatic logic [15:0] interleave_row(input logic [7:0] lo,
                                                   input logic [7:0] hi);
        logic [15:0] word;
        word = '0;
        for (int c = 0; c < 8; c++) begin
            word[2*c]   = lo[c];
            word[2*c+1] = hi[c];
        end
        return word;
    endfunction

endpackage

// ===== rtl/tile_2bpp_to_raster_converter_top.sv =====
// Top level of the 2bpp tile to raster converter.
// Depends on t2r_pkg, t2r_ctrl and t2r_dpath.
//
// Usage:
//   Input channel (in_valid/in_ready): command 0 loads one tile row given as
//   low_plane/high_plane bytes, tiles in column-major order; command 1 reads
//   the next eight raster pixels once the whole image is loaded.
//   Output channel (out_valid/out_ready): one word per pixel with its index,
//   gray level, palette RGB, last_of_span and end_of_image.
//   Configuration: cfg_write with cfg_index/cfg_data, only while idle.
// Operation:
//   A load is accepted in the idle state, then runs the serial tile/height
//   divider at one quotient bit per cycle and ends in a store write state.
//   A read is accepted, then emits its eight pixels through the single output
//   register; loads and early reads give no words.
//   The next word is accepted while the last pixel still waits in the output
//   register. A stalled receiver holds the output register and pauses the
//   span. Reset restores configuration defaults and clears both counters;
//   the pixel store is not cleared and needs no clearing pass.
module tile_2bpp_to_raster_converter_top #(
    parameter int MAX_TILES_SIDE = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [t2r_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [t2r_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [7:0]                      low_plane,
    input  logic [7:0]                      high_plane,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      pixel_index,
    output logic [1:0]                      gray_level,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic                            last_of_span,
    output logic                            end_of_image
);

    t2r_pkg::t2r_cmd_t    cmd;
    t2r_pkg::t2r_status_t status;

    t2r_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .status   (status),
        .cmd      (cmd)
    );

    t2r_dpath #(
        .MAX_TILES_SIDE (MAX_TILES_SIDE)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .low_plane    (low_plane),
        .high_plane   (high_plane),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_index  (pixel_index),
        .gray_level   (gray_level),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .last_of_span (last_of_span),
        .end_of_image (end_of_image)
    );

endmodule

// ===== rtl/t2r_ctrl.sv =====
// Controller state machine of the tile to raster converter.
// Depends on t2r_pkg; drives commands into t2r_dpath.
module t2r_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  t2r_pkg::t2r_status_t status,
    output t2r_pkg::t2r_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_EMIT  = 4'b1000
    } t2r_state_t;

    t2r_state_t state_reg;
    t2r_state_t state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Decode next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == t2r_pkg::CMD_LOAD)
                    begin
                        if (status.load_ok)
                        begin
                            cmd.load_start = 1'b1;
                            state_next     = ST_DIV;
                        end
                    end
                    else if (status.image_full)
                    begin
                        cmd.read_start = 1'b1;
                        state_next     = ST_EMIT;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write_row = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.pix_last)
                    begin
                        cmd.span_done = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/t2r_dpath.sv =====
// Datapath of the tile to raster converter: registers, counters, divider,
// pixel store and output register. Depends on t2r_pkg; driven by t2r_ctrl.
module t2r_dpath #(
    parameter int MAX_TILES_SIDE = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [t2r_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [t2r_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [7:0]                          low_plane,
    input  logic [7:0]                          high_plane,
    input  t2r_pkg::t2r_cmd_t                   cmd,
    output t2r_pkg::t2r_status_t                status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          pixel_index,
    output logic [1:0]                          gray_level,
    output logic [7:0]                          red,
    output logic [7:0]                          green,
    output logic [7:0]                          blue,
    output logic                                last_of_span,
    output logic                                end_of_image
);

    localparam int DEPTH    = MAX_TILES_SIDE * MAX_TILES_SIDE * 8;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SIDE_W   = $clog2(MAX_TILES_SIDE + 1);
    localparam int CMP_W    = (SIDE_W > 4) ? SIDE_W : 4;
    localparam int TILE_W   = (MAX_TILES_SIDE > 1) ?
                              $clog2(MAX_TILES_SIDE * MAX_TILES_SIDE) : 1;
    localparam int DCNT_W   = $clog2(TILE_W + 1);
    localparam int PROD_W   = 2 * SIDE_W + 3;
    localparam int TOT_W    = 2 * SIDE_W + 3;

    // Configuration registers
    logic [3:0]  width_tiles_reg;
    logic [3:0]  height_tiles_reg;
    logic [23:0] palette_reg [4];

    // Counters
    logic [CNT_W-1:0] rows_loaded_reg;
    logic [CNT_W-1:0] read_position_reg;

    // Divider and load row
    logic [SIDE_W-1:0] rem_reg;
    logic [TILE_W-1:0] quo_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [15:0]       row_word_reg;

    // Store and span emission
    logic [15:0] pixel_store [DEPTH];
    logic [15:0] span_q_reg;
    logic [2:0]  pix_cnt_reg;

    // Output register
    logic        out_valid_reg;
    logic [1:0]  pixel_index_reg;
    logic [23:0] color_reg;
    logic        last_reg;
    logic        end_reg;

    logic [SIDE_W-1:0] w_side;
    logic [SIDE_W-1:0] h_side;
    logic [TOT_W-1:0]  total;
    logic [TOT_W:0]    read_pos_inc;
    logic              ends;
    logic [SIDE_W:0]   trial;
    logic              trial_ge;
    logic [PROD_W-1:0] entry;
    logic [1:0]        pix_sel;

    // Clamp sizes to 1..MAX_TILES_SIDE
    always_comb
    begin
        if (width_tiles_reg == 4'd0)
        begin
            w_side = SIDE_W'(1);
        end
        else if (CMP_W'(width_tiles_reg) > CMP_W'(MAX_TILES_SIDE))
        begin
            w_side = SIDE_W'(MAX_TILES_SIDE);
        end
        else
        begin
            w_side = SIDE_W'(width_tiles_reg);
        end
        if (height_tiles_reg == 4'd0)
        begin
            h_side = SIDE_W'(1);
        end
        else if (CMP_W'(height_tiles_reg) > CMP_W'(MAX_TILES_SIDE))
        begin
            h_side = SIDE_W'(MAX_TILES_SIDE);
        end
        else
        begin
            h_side = SIDE_W'(height_tiles_reg);
        end
    end

    // Total rows of the image and end-of-image test
    assign total        = {TOT_W'(w_side) * TOT_W'(h_side)} << 3;
    assign read_pos_inc = (TOT_W + 1)'(read_position_reg) + (TOT_W + 1)'(1);
    assign ends         = (read_pos_inc >= (TOT_W + 1)'(total));

    // Restoring division step: tile / height
    assign trial    = {rem_reg, quo_reg[TILE_W-1]};
    assign trial_ge = (trial >= (SIDE_W + 1)'(h_side));

    // Raster entry: (tile_row * 8 + row_in_tile) * width + tile_column
    assign entry = PROD_W'({rem_reg, rows_loaded_reg[2:0]}) * PROD_W'(w_side)
                 + PROD_W'(quo_reg);

    // Status to controller
    assign status.load_ok    = ((TOT_W + 1)'(rows_loaded_reg) < (TOT_W + 1)'(total));
    assign status.image_full = !status.load_ok;
    assign status.div_last   = (div_cnt_reg == DCNT_W'(TILE_W - 1));
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.pix_last   = (pix_cnt_reg == 3'(t2r_pkg::PIXELS_PER_SPAN - 1));

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_tiles_reg  <= t2r_pkg::SIDE_RESET;
            height_tiles_reg <= t2r_pkg::SIDE_RESET;
            palette_reg[0]   <= t2r_pkg::PALETTE0_RESET;
            palette_reg[1]   <= t2r_pkg::PALETTE1_RESET;
            palette_reg[2]   <= t2r_pkg::PALETTE2_RESET;
            palette_reg[3]   <= t2r_pkg::PALETTE3_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                t2r_pkg::REG_WIDTH_TILES:  width_tiles_reg  <= cfg_data[3:0];
                t2r_pkg::REG_HEIGHT_TILES: height_tiles_reg <= cfg_data[3:0];
                t2r_pkg::REG_PALETTE_0:    palette_reg[0]   <= cfg_data;
                t2r_pkg::REG_PALETTE_1:    palette_reg[1]   <= cfg_data;
                t2r_pkg::REG_PALETTE_2:    palette_reg[2]   <= cfg_data;
                t2r_pkg::REG_PALETTE_3:    palette_reg[3]   <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Advance load and read counters, clearing both at the end of the image
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_loaded_reg   <= '0;
            read_position_reg <= '0;
        end
        else if (cmd.write_row)
        begin
            rows_loaded_reg <= rows_loaded_reg + CNT_W'(1);
        end
        else if (cmd.span_done)
        begin
            if (ends)
            begin
                rows_loaded_reg   <= '0;
                read_position_reg <= '0;
            end
            else
            begin
                read_position_reg <= read_position_reg + CNT_W'(1);
            end
        end
    end

    // Latch the interleaved row and divide tile number by height, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load_start)
        begin
            rem_reg      <= '0;
            quo_reg      <= rows_loaded_reg[TILE_W+2:3];
            div_cnt_reg  <= '0;
            row_word_reg <= t2r_pkg::interleave_row(low_plane, high_plane);
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= trial_ge ? SIDE_W'(trial - (SIDE_W + 1)'(h_side))
                                    : SIDE_W'(trial);
            quo_reg     <= (quo_reg << 1) | TILE_W'(trial_ge);
            div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
        end
    end

    // Pixel store with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.write_row)
        begin
            pixel_store[entry[ADDR_W-1:0]] <= row_word_reg;
        end
        if (cmd.read_start)
        begin
            span_q_reg <= pixel_store[read_position_reg[ADDR_W-1:0]];
        end
    end

    // Count pixels within the span
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_cnt_reg <= '0;
        end
        else if (cmd.read_start)
        begin
            pix_cnt_reg <= '0;
        end
        else if (cmd.emit)
        begin
            pix_cnt_reg <= pix_cnt_reg + 3'd1;
        end
    end

    // Select the current pixel, leftmost first
    assign pix_sel = span_q_reg[15 - 2 * pix_cnt_reg -: 2];

    // Hold output word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pixel_index_reg <= pix_sel;
            color_reg       <= palette_reg[pix_sel];
            last_reg        <= status.pix_last;
            end_reg         <= status.pix_last && ends;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_index  = pixel_index_reg;
    assign gray_level   = t2r_pkg::GRAY_MAX - pixel_index_reg;
    assign red          = color_reg[23:16];
    assign green        = color_reg[15:8];
    assign blue         = color_reg[7:0];
    assign last_of_span = last_reg;
    assign end_of_image = end_reg;

endmodule
